// ----- src/fse_pkg.sv -----
// package: sizes, command and status codes, state encoding for the frame stack engine
package fse_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned CMD_W  = 4;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PTR_W  = $clog2(DEPTH + 1);
  // width that holds pointer plus size without wrapping
  localparam int unsigned CMP_W  = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;

  localparam logic [WORD_W-1:0] DEPTH_WORD = WORD_W'(DEPTH);
  localparam logic [CMP_W-1:0]  DEPTH_CMP  = CMP_W'(DEPTH);
  localparam logic [PTR_W-1:0]  DEPTH_PTR  = PTR_W'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME_PUSH  = 4'd0,
    CMD_FRAME_POP   = 4'd1,
    CMD_PUSH        = 4'd2,
    CMD_POP         = 4'd3,
    CMD_LOAD_FRAME  = 4'd4,
    CMD_LOAD_STACK  = 4'd5,
    CMD_STORE_FRAME = 4'd6,
    CMD_STORE_STACK = 4'd7,
    CMD_ALLOC       = 4'd8,
    CMD_ALLOCZ      = 4'd9,
    CMD_DEALLOC     = 4'd10
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_UNF = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WR2,
    S_PF1,
    S_PF2,
    S_RD,
    S_ZERO
  } state_e;

endpackage

// ----- src/fse_if.sv -----
// valid/ready channel interfaces for command and result beats

interface fse_in_if;
  logic                          valid;
  logic                          ready;
  logic [fse_pkg::CMD_W-1:0]     command;
  logic [fse_pkg::WORD_W-1:0]    push_value;
  logic [fse_pkg::SIZE_W-1:0]    size_words;

  modport source (output valid, command, push_value, size_words, input ready);
  modport sink   (input valid, command, push_value, size_words, output ready);
endinterface

interface fse_out_if;
  logic                          valid;
  logic                          ready;
  logic [fse_pkg::WORD_W-1:0]    read_value;
  logic [fse_pkg::ST_W-1:0]      status;
  logic [fse_pkg::PTR_W-1:0]     stack_top;
  logic [fse_pkg::PTR_W-1:0]     frame_top;

  modport source (output valid, read_value, status, stack_top, frame_top, input ready);
  modport sink   (input valid, read_value, status, stack_top, frame_top, output ready);
endinterface

// ----- src/frame_stack_engine_core.sv -----
// frame stack engine top level: command sequencer around the stack word ram
// command beat to result beat: push, store, alloc, dealloc and errors caught on the
//   pointers finish in S_EXEC; pop and load read in S_EXEC and finish in S_RD; frame
//   push writes the value in S_EXEC, the old frame pointer in S_WR2; frame pop reads
//   the saved frame pointer in S_EXEC, takes it in S_PF1, finishes in S_PF2; zero
//   allocation: one ram write per cleared word in S_ZERO; one command at a time
// a command beat is taken while the previous result still waits in the output register
// reset (async, active low) clears both pointers, the sequencer and the output valid;
//   stack words are undefined until written
module frame_stack_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  fse_in_if.sink     in_i,
  fse_out_if.source  out_o
);

  localparam int unsigned ADDR_W = fse_pkg::ADDR_W;
  localparam int unsigned PTR_W  = fse_pkg::PTR_W;
  localparam int unsigned CMP_W  = fse_pkg::CMP_W;
  localparam int unsigned WORD_W = fse_pkg::WORD_W;
  localparam int unsigned SIZE_W = fse_pkg::SIZE_W;

  // sequencer and pointer state
  fse_pkg::state_e state_q, state_d;
  logic [PTR_W-1:0] top_q, top_d;
  logic [PTR_W-1:0] frame_q, frame_d;
  logic [PTR_W-1:0] zf_rem_q, zf_rem_d;
  logic [ADDR_W-1:0] zf_addr_q, zf_addr_d;

  // latched command beat (payload, no reset)
  logic [fse_pkg::CMD_W-1:0] cmd_q;
  logic [WORD_W-1:0]         val_q;
  logic [SIZE_W-1:0]         size_q;
  logic [WORD_W-1:0]         w_q, w_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic [WORD_W-1:0]         out_rd_q, out_rd_d;
  logic [fse_pkg::ST_W-1:0]  out_st_q, out_st_d;
  logic [PTR_W-1:0]          out_top_q, out_top_d;
  logic [PTR_W-1:0]          out_frame_q, out_frame_d;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // result of the finishing cycle
  logic               finish;
  fse_pkg::status_e   fin_st;
  logic [WORD_W-1:0]  fin_rd;

  logic in_beat;
  logic out_free;
  fse_pkg::cmd_e cmd;

  // pointer arithmetic and checks
  logic [CMP_W-1:0] top_x, frame_x, size_x, top_plus, frame_plus, top_minus;
  logic [PTR_W-1:0] tm1, fm1, fm2;
  logic room_lt2, stack_full, frame_short, no_used, sz_zero, sz_ovf, sz_unf;
  logic rd_ovf, saved_ovf, saved_unf;

  assign in_beat  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign cmd      = fse_pkg::cmd_e'(cmd_q);

  assign top_x      = {{(CMP_W-PTR_W){1'b0}}, top_q};
  assign frame_x    = {{(CMP_W-PTR_W){1'b0}}, frame_q};
  assign size_x     = {{(CMP_W-SIZE_W){1'b0}}, size_q};
  assign top_plus   = top_x + size_x;
  assign frame_plus = frame_x + size_x;
  assign top_minus  = top_x - size_x;
  assign tm1        = top_q - PTR_W'(1);
  assign fm1        = frame_q - PTR_W'(1);
  assign fm2        = frame_q - PTR_W'(2);

  assign room_lt2    = (top_x + CMP_W'(2)) > fse_pkg::DEPTH_CMP;
  assign stack_full  = top_q >= fse_pkg::DEPTH_PTR;
  assign frame_short = frame_q < PTR_W'(2);
  // used words (top minus frame, signed) below one
  assign no_used     = top_q <= frame_q;
  assign sz_zero     = size_q == '0;
  assign sz_ovf      = top_plus > fse_pkg::DEPTH_CMP;
  // size above used words; also true whenever the top lies below the frame
  assign sz_unf      = frame_plus > top_x;
  // word read back by a pointer load (pop does not use this check)
  assign rd_ovf      = ram_rdata > fse_pkg::DEPTH_WORD;
  // saved frame pointer of a frame pop, held in w_q
  assign saved_ovf   = w_q > fse_pkg::DEPTH_WORD;
  assign saved_unf   = {{(WORD_W-PTR_W){1'b0}}, top_q} < w_q;

  fse_ram #(
    .WIDTH (WORD_W),
    .DEPTH (fse_pkg::DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fse_pkg::S_IDLE: begin
        if (in_beat) state_d = fse_pkg::S_EXEC;
      end
      fse_pkg::S_EXEC: begin
        unique case (cmd)
          fse_pkg::CMD_FRAME_PUSH: begin
            if (!room_lt2) state_d = fse_pkg::S_WR2;
            else if (out_free) state_d = fse_pkg::S_IDLE;
          end
          fse_pkg::CMD_FRAME_POP: begin
            if (!frame_short) state_d = fse_pkg::S_PF1;
            else if (out_free) state_d = fse_pkg::S_IDLE;
          end
          fse_pkg::CMD_POP, fse_pkg::CMD_LOAD_FRAME, fse_pkg::CMD_LOAD_STACK: begin
            if (!no_used) state_d = fse_pkg::S_RD;
            else if (out_free) state_d = fse_pkg::S_IDLE;
          end
          fse_pkg::CMD_ALLOCZ: begin
            if (!sz_zero && !sz_ovf) state_d = fse_pkg::S_ZERO;
            else if (out_free) state_d = fse_pkg::S_IDLE;
          end
          default: begin
            if (out_free) state_d = fse_pkg::S_IDLE;
          end
        endcase
      end
      fse_pkg::S_PF1: state_d = fse_pkg::S_PF2;
      fse_pkg::S_WR2, fse_pkg::S_PF2, fse_pkg::S_RD: begin
        if (out_free) state_d = fse_pkg::S_IDLE;
      end
      fse_pkg::S_ZERO: begin
        if (zf_rem_q == PTR_W'(1) && out_free) state_d = fse_pkg::S_IDLE;
      end
      default: state_d = fse_pkg::S_IDLE;
    endcase
  end

  // datapath, ram control and result
  always_comb begin
    finish    = 1'b0;
    fin_st    = fse_pkg::ST_OK;
    fin_rd    = '0;
    top_d     = top_q;
    frame_d   = frame_q;
    w_d       = w_q;
    zf_rem_d  = zf_rem_q;
    zf_addr_d = zf_addr_q;
    ram_we    = 1'b0;
    ram_waddr = top_q[ADDR_W-1:0];
    ram_wdata = val_q;
    ram_raddr = tm1[ADDR_W-1:0];

    unique case (state_q)
      fse_pkg::S_IDLE: begin
      end
      fse_pkg::S_EXEC: begin
        unique case (cmd)
          fse_pkg::CMD_FRAME_PUSH: begin
            if (room_lt2) begin
              finish = out_free;
              fin_st = fse_pkg::ST_OVF;
            end else begin
              // first word: the value
              ram_we = 1'b1;
            end
          end
          fse_pkg::CMD_FRAME_POP: begin
            ram_raddr = fm1[ADDR_W-1:0];
            if (frame_short) begin
              finish = out_free;
              fin_st = fse_pkg::ST_UNF;
            end
          end
          fse_pkg::CMD_PUSH, fse_pkg::CMD_STORE_FRAME, fse_pkg::CMD_STORE_STACK: begin
            finish = out_free;
            if (stack_full) begin
              fin_st = fse_pkg::ST_OVF;
            end else begin
              ram_we = out_free;
              if (cmd == fse_pkg::CMD_STORE_FRAME) begin
                ram_wdata = {{(WORD_W-PTR_W){1'b0}}, frame_q};
              end else if (cmd == fse_pkg::CMD_STORE_STACK) begin
                ram_wdata = {{(WORD_W-PTR_W){1'b0}}, top_q};
              end
              if (out_free) top_d = top_q + PTR_W'(1);
            end
          end
          fse_pkg::CMD_POP, fse_pkg::CMD_LOAD_FRAME, fse_pkg::CMD_LOAD_STACK: begin
            if (no_used) begin
              finish = out_free;
              fin_st = fse_pkg::ST_UNF;
            end
          end
          fse_pkg::CMD_ALLOC: begin
            finish = out_free;
            if (!sz_zero) begin
              if (sz_ovf) fin_st = fse_pkg::ST_OVF;
              else if (out_free) top_d = top_plus[PTR_W-1:0];
            end
          end
          fse_pkg::CMD_ALLOCZ: begin
            if (sz_zero) begin
              finish = out_free;
            end else if (sz_ovf) begin
              finish = out_free;
              fin_st = fse_pkg::ST_OVF;
            end else begin
              zf_rem_d  = top_plus[PTR_W-1:0] - top_q;
              zf_addr_d = top_q[ADDR_W-1:0];
            end
          end
          fse_pkg::CMD_DEALLOC: begin
            finish = out_free;
            if (!sz_zero) begin
              if (sz_unf) fin_st = fse_pkg::ST_UNF;
              else if (out_free) top_d = top_minus[PTR_W-1:0];
            end
          end
          default: begin
            // unused command codes: nothing changes, status ok
            finish = out_free;
          end
        endcase
      end
      fse_pkg::S_WR2: begin
        // second word: the old frame pointer, one above the value
        finish    = out_free;
        ram_we    = out_free;
        ram_waddr = top_q[ADDR_W-1:0] + ADDR_W'(1);
        ram_wdata = {{(WORD_W-PTR_W){1'b0}}, frame_q};
        if (out_free) begin
          top_d   = top_q + PTR_W'(2);
          frame_d = top_q + PTR_W'(2);
        end
      end
      fse_pkg::S_PF1: begin
        // saved frame pointer arrives; start reading the pushed value
        w_d       = ram_rdata;
        ram_raddr = fm2[ADDR_W-1:0];
      end
      fse_pkg::S_PF2: begin
        ram_raddr = fm2[ADDR_W-1:0];
        finish    = out_free;
        if (saved_ovf) begin
          fin_st = fse_pkg::ST_OVF;
        end else if (saved_unf) begin
          fin_st = fse_pkg::ST_UNF;
        end else begin
          fin_rd = ram_rdata;
          if (out_free) begin
            top_d   = fm2;
            frame_d = w_q[PTR_W-1:0];
          end
        end
      end
      fse_pkg::S_RD: begin
        finish = out_free;
        if (cmd == fse_pkg::CMD_POP) begin
          fin_rd = ram_rdata;
          if (out_free) top_d = tm1;
        end else if (rd_ovf) begin
          fin_st = fse_pkg::ST_OVF;
        end else if (out_free) begin
          if (cmd == fse_pkg::CMD_LOAD_FRAME) begin
            top_d   = tm1;
            frame_d = ram_rdata[PTR_W-1:0];
          end else begin
            top_d = ram_rdata[PTR_W-1:0];
          end
        end
      end
      fse_pkg::S_ZERO: begin
        // one cleared word per cycle; the last write repeats while the result stalls
        ram_we    = 1'b1;
        ram_waddr = zf_addr_q;
        ram_wdata = '0;
        if (zf_rem_q != PTR_W'(1)) begin
          zf_rem_d  = zf_rem_q - PTR_W'(1);
          zf_addr_d = zf_addr_q + ADDR_W'(1);
        end else if (out_free) begin
          finish   = 1'b1;
          zf_rem_d = '0;
          top_d    = top_plus[PTR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // output register load
  always_comb begin
    out_valid_d = out_valid_q;
    out_rd_d    = out_rd_q;
    out_st_d    = out_st_q;
    out_top_d   = out_top_q;
    out_frame_d = out_frame_q;
    if (finish) begin
      out_valid_d = 1'b1;
      out_rd_d    = fin_rd;
      out_st_d    = fin_st;
      out_top_d   = top_d;
      out_frame_d = frame_d;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fse_pkg::S_IDLE;
      top_q       <= '0;
      frame_q     <= '0;
      zf_rem_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      frame_q     <= frame_d;
      zf_rem_q    <= zf_rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      cmd_q  <= in_i.command;
      val_q  <= in_i.push_value;
      size_q <= in_i.size_words;
    end
    w_q         <= w_d;
    zf_addr_q   <= zf_addr_d;
    out_rd_q    <= out_rd_d;
    out_st_q    <= out_st_d;
    out_top_q   <= out_top_d;
    out_frame_q <= out_frame_d;
  end

  assign in_i.ready       = state_q == fse_pkg::S_IDLE;
  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_rd_q;
  assign out_o.status     = out_st_q;
  assign out_o.stack_top  = out_top_q;
  assign out_o.frame_top  = out_frame_q;

endmodule

// ----- src/fse_ram.sv -----
// generic simple dual-port ram, one write port, one registered read port
module fse_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
